@@ src/weekly_alarm_next_time_defines.svh @@
// Assertion macros shared by the weekly alarm next-time block.
// No dependencies; included by the checker file.
`ifndef WEEKLY_ALARM_NEXT_TIME_DEFINES_SVH
`define WEEKLY_ALARM_NEXT_TIME_DEFINES_SVH

// Same-cycle implication, disabled while rst is high
`define WANXT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define WANXT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/wanxt_pkg.sv @@
// Constants shared by the weekly alarm next-time block and its channel interfaces.
// No dependencies.
package wanxt_pkg;

   // Calendar constants; SECS_PER_DAY and SECS_PER_WEEK in seconds
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_WEEK = 7 * SECS_PER_DAY;
   localparam int DAYS_PER_WEEK = 7;

   // floor(log2(SECS_PER_WEEK)) and the bits needed to hold SECS_PER_WEEK
   localparam int WEEK_LOG2 = 19;
   localparam int WEEK_BITS = 20;

   // Fixed field widths of a rule
   localparam int GAP_BITS  = 16;
   localparam int MASK_BITS = 7;
   localparam int TOD_BITS  = 17;
   localparam int DAY_BITS  = 3;

endpackage

@@ src/wanxt_if.sv @@
// Valid/ready channel interfaces for the alarm rule (request) and next time (response).
// Depends on wanxt_pkg for the fixed field widths.
interface wanxt_req_if
   import wanxt_pkg::*;
#(
   parameter int TIME_BITS = 36
);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] now_time;
   logic                 repeating;
   logic [TIME_BITS-1:0] anchor_time;
   logic [GAP_BITS-1:0]  week_interval;
   logic [MASK_BITS-1:0] day_mask;
   logic [TOD_BITS-1:0]  time_of_day;
   logic                 force_reschedule;

   modport source (
      output valid, now_time, repeating, anchor_time, week_interval, day_mask,
             time_of_day, force_reschedule,
      input  ready
   );
   modport sink (
      input  valid, now_time, repeating, anchor_time, week_interval, day_mask,
             time_of_day, force_reschedule,
      output ready
   );
endinterface

interface wanxt_rsp_if #(
   parameter int TIME_BITS = 36
);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] next_alarm_time;
   logic                 never_fires;
   logic                 bad_rule;

   modport source (
      output valid, next_alarm_time, never_fires, bad_rule,
      input  ready
   );
   modport sink (
      input  valid, next_alarm_time, never_fires, bad_rule,
      output ready
   );
endinterface

@@ src/weekly_alarm_next_time.sv @@
// Weekly alarm next-time calculator: one shared adder under a small sequencer.
// Depends on wanxt_pkg and the wanxt_req_if / wanxt_rsp_if channel interfaces.
//
//   channel  | dir | handshake   | word
//   ---------+-----+-------------+----------------------------------------------
//   req_ch   | in  | valid/ready | now, repeating, anchor, interval, mask, tod, force
//   rsp_ch   | out | valid/ready | next_alarm_time, never_fires, bad_rule
//
// One-shot rule, or repeating rule with empty mask or zero interval: the result is set
//   in ST_DIFF and handed over from ST_FINISH.
// Repeating rule: every step uses the single adder: two restoring divisions, two shift-add
//   multiplies, then one add per day scanned; the scan ends early when an earlier weekday hits.
// req_ch.ready is high only while the sequencer is idle; a finished word waits in
//   rsp_ch's output register and the next rule may be accepted meanwhile.
// Synchronous active-high reset clears the sequencer and rsp_ch.valid.
module weekly_alarm_next_time
   import wanxt_pkg::*;
#(
   parameter int TIME_BITS       = 36,
   parameter int WEEK_STEP_LIMIT = 4
) (
   input  logic          clock,
   input  logic          reset,
   wanxt_req_if.sink     req_ch,
   wanxt_rsp_if.source   rsp_ch
);

   // Datapath widths
   localparam int XW = ((TIME_BITS > 41) ? TIME_BITS : 41) + 2;  // wide adder
   localparam int QW = TIME_BITS - WEEK_LOG2;                    // elapsed weeks
   localparam int NW = ((QW > GAP_BITS) ? QW : GAP_BITS) + 1;    // rounded weeks
   localparam int RW = WEEK_BITS + 1;                            // division remainder
   localparam int CW = $clog2(NW);
   localparam int SW = $clog2(WEEK_STEP_LIMIT);

   localparam logic [XW-1:0]        WEEK_X   = XW'(SECS_PER_WEEK);
   localparam logic [XW-1:0]        DAY_X    = XW'(SECS_PER_DAY);
   localparam logic [CW-1:0]        DIV1_END = CW'(QW - 1);
   localparam logic [CW-1:0]        DIV2_END = CW'(NW - 1);
   localparam logic [CW-1:0]        MULG_END = CW'(GAP_BITS - 1);
   localparam logic [DAY_BITS-1:0]  LAST_DAY = DAY_BITS'(DAYS_PER_WEEK - 1);
   localparam logic [SW-1:0]        LAST_STEP = SW'(WEEK_STEP_LIMIT - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_DIV1,
      ST_PREP2,
      ST_DIV2,
      ST_MULG,
      ST_MULQ,
      ST_WEEK,
      ST_DAY,
      ST_NEXT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Latched rule
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] anchor_ff, anchor_in;
   logic [GAP_BITS-1:0]  gap_ff, gap_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic [TOD_BITS-1:0]  tod_ff, tod_in;
   logic                 rep_ff, rep_in;
   logic                 force_ff, force_in;

   // Division / multiply working registers
   logic [RW-1:0]        rem_ff, rem_in;
   logic [NW-1:0]        dvd_ff, dvd_in;   // dividend bits, later the multiplier
   logic [NW-1:0]        quo_ff, quo_in;
   logic [XW-1:0]        acc_ff, acc_in;
   logic [XW-1:0]        mcand_ff, mcand_in;
   logic [XW-1:0]        gapw_ff, gapw_in; // interval length in seconds
   logic [CW-1:0]        cnt_ff, cnt_in;

   // Scan registers
   logic [XW-1:0]        cand_ff, cand_in;
   logic [DAY_BITS-1:0]  day_ff, day_in;
   logic [SW-1:0]        step_ff, step_in;

   // Pending result and output word
   logic [TIME_BITS-1:0] res_time_ff, res_time_in;
   logic                 res_never_ff, res_never_in;
   logic                 res_bad_ff, res_bad_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0] rsp_time_ff, rsp_time_in;
   logic                 rsp_never_ff, rsp_never_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   // Shared adder/subtractor
   logic [XW-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [XW:0]   alu_sum;
   logic          alu_nb;          // no borrow: a >= b on subtract

   logic [TIME_BITS-1:0] diff;
   logic [XW-1:0]        div_shift;
   logic [XW-1:0]        acc_step;
   logic [GAP_BITS-1:0]  gap_m1;
   logic [XW-1:0]        now_x;
   logic                 day_hit;
   logic                 over_range;

   // Operand selection for the shared adder
   always_comb begin
      div_shift = {{(XW-RW){1'b0}}, rem_ff[RW-2:0], dvd_ff[NW-1]};
      gap_m1    = gap_ff - GAP_BITS'(1);
      alu_a     = '0;
      alu_b     = '0;
      alu_sub   = 1'b0;
      case (state_ff)
         ST_DIFF: begin
            alu_a   = {{(XW-TIME_BITS){1'b0}}, now_ff};
            alu_b   = {{(XW-TIME_BITS){1'b0}}, anchor_ff};
            alu_sub = 1'b1;
         end
         ST_DIV1: begin
            alu_a   = div_shift;
            alu_b   = WEEK_X;
            alu_sub = 1'b1;
         end
         ST_PREP2: begin
            alu_a = {{(XW-NW){1'b0}}, quo_ff};
            alu_b = {{(XW-GAP_BITS){1'b0}}, gap_m1};
         end
         ST_DIV2: begin
            alu_a   = div_shift;
            alu_b   = {{(XW-GAP_BITS){1'b0}}, gap_ff};
            alu_sub = 1'b1;
         end
         ST_MULG, ST_MULQ: begin
            alu_a = acc_ff;
            alu_b = mcand_ff;
         end
         ST_WEEK: begin
            alu_a = acc_ff;
            alu_b = {{(XW-TOD_BITS){1'b0}}, tod_ff};
         end
         ST_DAY: begin
            alu_a = cand_ff;
            alu_b = DAY_X;
         end
         ST_NEXT: begin
            alu_a = acc_ff;
            alu_b = gapw_ff;
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b0;
         end
      endcase
      alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {{XW{1'b0}}, alu_sub};
      alu_nb  = alu_sum[XW];
   end

   // Sequencer next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      anchor_in    = anchor_ff;
      gap_in       = gap_ff;
      mask_in      = mask_ff;
      tod_in       = tod_ff;
      rep_in       = rep_ff;
      force_in     = force_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      gapw_in      = gapw_ff;
      cnt_in       = cnt_ff;
      cand_in      = cand_ff;
      day_in       = day_ff;
      step_in      = step_ff;
      res_time_in  = res_time_ff;
      res_never_in = res_never_ff;
      res_bad_in   = res_bad_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_never_in = rsp_never_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      diff       = alu_nb ? alu_sum[TIME_BITS-1:0] : '0;
      acc_step   = dvd_ff[0] ? alu_sum[XW-1:0] : acc_ff;
      now_x      = {{(XW-TIME_BITS){1'b0}}, now_ff};
      day_hit    = mask_ff[day_ff] && (cand_ff > now_x);
      over_range = |cand_ff[XW-1:TIME_BITS];

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               now_in    = req_ch.now_time;
               anchor_in = req_ch.anchor_time;
               gap_in    = req_ch.week_interval;
               mask_in   = req_ch.day_mask;
               tod_in    = req_ch.time_of_day;
               rep_in    = req_ch.repeating;
               force_in  = req_ch.force_reschedule;
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            res_time_in  = '1;
            res_never_in = 1'b0;
            res_bad_in   = 1'b0;
            if (!rep_ff) begin
               // one-shot: anchor has passed when now > anchor
               if (alu_nb && (alu_sum[TIME_BITS-1:0] != '0) && !force_ff) begin
                  res_never_in = 1'b1;
               end else begin
                  res_time_in = anchor_ff;
               end
               state_in = ST_FINISH;
            end else if ((mask_ff == '0) || (gap_ff == '0)) begin
               res_bad_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               // top bits of the elapsed time are below one week
               rem_in   = {{(RW-WEEK_LOG2){1'b0}}, diff[TIME_BITS-1:QW]};
               dvd_in   = {diff[QW-1:0], {(NW-QW){1'b0}}};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1, ST_DIV2: begin
            // one restoring division step
            rem_in = alu_nb ? alu_sum[RW-1:0] : div_shift[RW-1:0];
            quo_in = {quo_ff[NW-2:0], alu_nb};
            dvd_in = {dvd_ff[NW-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if ((state_ff == ST_DIV1) && (cnt_ff == DIV1_END)) begin
               state_in = ST_PREP2;
            end else if ((state_ff == ST_DIV2) && (cnt_ff == DIV2_END)) begin
               acc_in   = '0;
               mcand_in = WEEK_X;
               dvd_in   = {{(NW-GAP_BITS){1'b0}}, gap_ff};
               cnt_in   = '0;
               state_in = ST_MULG;
            end
         end
         ST_PREP2: begin
            // numerator for the round-up division: weeks + interval - 1
            dvd_in   = alu_sum[NW-1:0];
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV2;
         end
         ST_MULG, ST_MULQ: begin
            // one shift-add multiply step
            acc_in   = acc_step;
            mcand_in = {mcand_ff[XW-2:0], 1'b0};
            dvd_in   = {1'b0, dvd_ff[NW-1:1]};
            cnt_in   = cnt_ff + CW'(1);
            if ((state_ff == ST_MULG) && (cnt_ff == MULG_END)) begin
               gapw_in  = acc_step;
               acc_in   = {{(XW-TIME_BITS){1'b0}}, anchor_ff};
               mcand_in = acc_step;
               dvd_in   = quo_ff;
               cnt_in   = '0;
               state_in = ST_MULQ;
            end else if ((state_ff == ST_MULQ) && (cnt_ff == DIV2_END)) begin
               step_in  = '0;
               state_in = ST_WEEK;
            end
         end
         ST_WEEK: begin
            cand_in  = alu_sum[XW-1:0];
            day_in   = '0;
            state_in = ST_DAY;
         end
         ST_DAY: begin
            res_never_in = 1'b0;
            if (day_hit) begin
               res_time_in = over_range ? '1 : cand_ff[TIME_BITS-1:0];
               res_bad_in  = over_range;
               state_in    = ST_FINISH;
            end else if (day_ff == LAST_DAY) begin
               if (step_ff == LAST_STEP) begin
                  res_time_in = '1;
                  res_bad_in  = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  state_in = ST_NEXT;
               end
            end else begin
               cand_in = alu_sum[XW-1:0];
               day_in  = day_ff + DAY_BITS'(1);
            end
         end
         ST_NEXT: begin
            acc_in   = alu_sum[XW-1:0];
            step_in  = step_ff + SW'(1);
            state_in = ST_WEEK;
         end
         ST_FINISH: begin
            // hand the word over once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = res_time_ff;
               rsp_never_in = res_never_ff;
               rsp_bad_in   = res_bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff       <= now_in;
      anchor_ff    <= anchor_in;
      gap_ff       <= gap_in;
      mask_ff      <= mask_in;
      tod_ff       <= tod_in;
      rep_ff       <= rep_in;
      force_ff     <= force_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      gapw_ff      <= gapw_in;
      cnt_ff       <= cnt_in;
      cand_ff      <= cand_in;
      day_ff       <= day_in;
      step_ff      <= step_in;
      res_time_ff  <= res_time_in;
      res_never_ff <= res_never_in;
      res_bad_ff   <= res_bad_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_never_ff <= rsp_never_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // Channel outputs
   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.next_alarm_time = rsp_time_ff;
   assign rsp_ch.never_fires     = rsp_never_ff;
   assign rsp_ch.bad_rule        = rsp_bad_ff;

endmodule

@@ src/wanxt_checker.sv @@
// Port-level checks for weekly_alarm_next_time, attached by bind.
// Depends on weekly_alarm_next_time_defines.svh for the assertion macros.
`include "weekly_alarm_next_time_defines.svh"

module wanxt_checker #(
   parameter int TIME_BITS = 36
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [TIME_BITS-1:0] next_alarm_time,
   input logic                 never_fires,
   input logic                 bad_rule
);

   // no word on the output right after reset
   `WANXT_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

   // a stalled word holds
   `WANXT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(next_alarm_time) && $stable(never_fires) && $stable(bad_rule), "rsp word changed while stalled")

   // the block is not ready in the cycle after it takes a rule
   `WANXT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")

   // an outdated one-shot reports all ones and a good rule
   `WANXT_ASSERT_NOW(a_never_word, clock, reset, rsp_valid && never_fires, (next_alarm_time == '1) && !bad_rule, "never_fires word malformed")

   // a bad rule reports all ones and is not a one-shot
   `WANXT_ASSERT_NOW(a_bad_word, clock, reset, rsp_valid && bad_rule, (next_alarm_time == '1) && !never_fires, "bad_rule word malformed")

endmodule

bind weekly_alarm_next_time wanxt_checker #(
   .TIME_BITS (TIME_BITS)
) u_wanxt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .next_alarm_time (rsp_ch.next_alarm_time),
   .never_fires     (rsp_ch.never_fires),
   .bad_rule        (rsp_ch.bad_rule)
);
